// ----- sv/rma_pkg.sv -----
package rma_pkg;

   localparam int REGIONS = 4;
   localparam int GRID_MAX = 64;
   localparam int GRID_BITS = $clog2(GRID_MAX);
   localparam int WIDTH_BITS = 7;
   localparam int TRAIN_BITS = 8;
   localparam int COUNT_BITS = 13;
   localparam int FIELD_BITS = 6;
   localparam int THRESH_BITS = 7;
   localparam int INDEX_BITS = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int PENDING_BITS = $clog2(REGIONS + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [THRESH_BITS:0] PERCENT_FULL = 8'd100;

   localparam logic [WIDTH_BITS-1:0] GRID_WIDTH_RESET = 7'd60;
   localparam logic [TRAIN_BITS-1:0] TRAINING_RESET = 8'd15;
   localparam logic [CSR_DATA_BITS-1:0] REGION_RESET = 32'h6400_0000;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_GRID_WIDTH = 3'd0,
      REG_TRAINING   = 3'd1,
      REG_REGION0    = 3'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_UNSET     = 2'd0,
      ST_TRAINING  = 2'd1,
      ST_NO_MOTION = 2'd2,
      ST_MOTION    = 2'd3
   } status_type;

   typedef struct packed {
      logic                   enable;
      logic [THRESH_BITS-1:0] thresh;
      logic [FIELD_BITS-1:0]  end_row;
      logic [FIELD_BITS-1:0]  end_col;
      logic [FIELD_BITS-1:0]  start_row;
      logic [FIELD_BITS-1:0]  start_col;
   } region_type;

   // block position and per-block control broadcast to every cell
   typedef struct packed {
      logic [GRID_BITS-1:0] column;
      logic [GRID_BITS-1:0] row;
      logic                 clear;
      logic                 count_en;
      logic                 capture;
   } block_type;

   // output chain control
   typedef struct packed {
      logic load;
      logic shift;
   } chain_type;

endpackage

// ----- sv/region_motion_alarm.sv -----
// Region motion alarm: takes one motion-grid block per cycle in raster order (req_tlast marks
// the last block of a frame) and keeps block and clear-block counts for four rectangular
// regions in a row of region cells. A frame end snapshots the counts; every cell judges
// its region from the snapshot, and once the chain is free the statuses load into a shift
// chain and leave region 0 first, one per cycle while rsp_tready is high, on the rsp channel
// with rsp_tlast on region 3. Blocks that do not end a frame are taken every cycle; a frame
// end is taken once the snapshot stage is free.
module region_motion_alarm
   import rma_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [0] flag_clear
   input  logic                      req_tuser,   // [0] frame_restart
   input  logic                      req_tlast,   // frame_end
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,   // [1:0] region_status
   output logic [INDEX_BITS-1:0]     rsp_tuser,   // [1:0] region_index
   output logic                      rsp_tlast,   // last_region
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic [WIDTH_BITS-1:0]   grid_width_ff;
   logic [TRAIN_BITS-1:0]   training_ff;
   region_type              region_ff [REGIONS];
   logic                    snap_valid_ff, snap_valid_in;
   logic                    training_snap_ff;
   logic [PENDING_BITS-1:0] pending_ff, pending_in;
   logic                    accept;
   logic                    capture;
   logic                    training_now;
   logic [GRID_BITS-1:0]    column;
   logic [GRID_BITS-1:0]    row;
   block_type               blk;
   chain_type               chain;
   status_type              link [REGIONS+1];
   logic [INDEX_BITS-1:0]   out_index;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= GRID_WIDTH_RESET;
         training_ff <= TRAINING_RESET;
         for (int r = 0; r < REGIONS; r++) begin
            region_ff[r] <= region_type'(REGION_RESET);
         end
      end else if (csr_valid) begin
         if (csr_index == REG_GRID_WIDTH) begin
            grid_width_ff <= csr_data[WIDTH_BITS-1:0];
         end else if (csr_index == REG_TRAINING) begin
            training_ff <= csr_data[TRAIN_BITS-1:0];
         end
         for (int r = 0; r < REGIONS; r++) begin
            if (csr_index == CSR_INDEX_BITS'(int'(REG_REGION0) + r)) begin
               region_ff[r] <= region_type'(csr_data);
            end
         end
      end
   end

   // output chain control
   assign chain.shift = rsp_tvalid && rsp_tready;
   assign chain.load = snap_valid_ff &&
                       ((pending_ff == '0) ||
                        ((pending_ff == PENDING_BITS'(1)) && rsp_tready));

   // a frame end needs the snapshot stage free; other blocks always go through
   assign req_tready = !req_tlast || !snap_valid_ff || chain.load;
   assign accept = req_tvalid && req_tready;
   assign capture = accept && req_tlast;

   always_comb begin
      snap_valid_in = snap_valid_ff;
      if (capture) begin
         snap_valid_in = 1'b1;
      end else if (chain.load) begin
         snap_valid_in = 1'b0;
      end
   end

   always_comb begin
      pending_in = pending_ff;
      if (chain.load) begin
         pending_in = PENDING_BITS'(REGIONS);
      end else if (chain.shift) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
         pending_ff <= '0;
      end else begin
         snap_valid_ff <= snap_valid_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         training_snap_ff <= training_now;
      end
   end

   rma_tracker u_tracker (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .restart         (req_tuser),
      .frame_end       (req_tlast),
      .grid_width      (grid_width_ff),
      .training_frames (training_ff),
      .column          (column),
      .row             (row),
      .training        (training_now)
   );

   assign blk.column = column;
   assign blk.row = row;
   assign blk.clear = req_tdata[0];
   assign blk.count_en = accept;
   assign blk.capture = req_tlast;

   assign link[REGIONS] = ST_UNSET;

   for (genvar r = 0; r < REGIONS; r++) begin : g_cell
      rma_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .blk      (blk),
         .region   (region_ff[r]),
         .training (training_snap_ff),
         .chain    (chain),
         .link_in  (link[r+1]),
         .link_out (link[r])
      );
   end

   assign out_index = INDEX_BITS'(REGIONS - int'(pending_ff));

   assign rsp_tvalid = pending_ff != '0;
   assign rsp_tdata = {6'b0, link[0]};
   assign rsp_tuser = out_index;
   assign rsp_tlast = pending_ff == PENDING_BITS'(1);

endmodule

// ----- sv/rma_tracker.sv -----
module rma_tracker
   import rma_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  restart,
   input  logic                  frame_end,
   input  logic [WIDTH_BITS-1:0] grid_width,
   input  logic [TRAIN_BITS-1:0] training_frames,
   output logic [GRID_BITS-1:0]  column,
   output logic [GRID_BITS-1:0]  row,
   output logic                  training
);

   logic [GRID_BITS-1:0]  column_ff, column_in;
   logic [GRID_BITS-1:0]  row_ff, row_in;
   logic [TRAIN_BITS-1:0] frames_ff, frames_in;
   logic [TRAIN_BITS-1:0] frames_now;
   logic [WIDTH_BITS-1:0] eff_width;
   logic [WIDTH_BITS-1:0] column_next;
   logic                  first;

   assign first = (column_ff == '0) && (row_ff == '0);

   always_comb begin
      if (grid_width == '0) begin
         eff_width = WIDTH_BITS'(1);
      end else if (grid_width > WIDTH_BITS'(GRID_MAX)) begin
         eff_width = WIDTH_BITS'(GRID_MAX);
      end else begin
         eff_width = grid_width;
      end
   end

   // frame counter as seen by this block, after the frame-start update
   always_comb begin
      frames_now = frames_ff;
      if (first) begin
         if (restart) begin
            frames_now = '0;
         end else if (frames_ff < training_frames) begin
            frames_now = frames_ff + 1'b1;
         end
      end
   end

   assign column_next = WIDTH_BITS'(column_ff) + 1'b1;

   always_comb begin
      column_in = column_ff;
      row_in = row_ff;
      frames_in = frames_ff;
      if (accept) begin
         frames_in = frames_now;
         if (frame_end) begin
            column_in = '0;
            row_in = '0;
         end else if (column_next >= eff_width) begin
            column_in = '0;
            if (row_ff != GRID_BITS'(GRID_MAX - 1)) begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            column_in = column_next[GRID_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff <= '0;
         frames_ff <= '0;
      end else begin
         column_ff <= column_in;
         row_ff <= row_in;
         frames_ff <= frames_in;
      end
   end

   assign column = column_ff;
   assign row = row_ff;
   assign training = frames_now < training_frames;

endmodule

// ----- sv/rma_cell.sv -----
module rma_cell
   import rma_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  block_type  blk,
   input  region_type region,
   input  logic       training,
   input  chain_type  chain,
   input  status_type link_in,
   output status_type link_out
);

   logic [COUNT_BITS-1:0] total_ff, total_in, total_upd;
   logic [COUNT_BITS-1:0] clear_ff, clear_in, clear_upd;
   logic [COUNT_BITS-1:0] snap_total_ff, snap_clear_ff;
   status_type            link_ff, link_in_next;
   status_type            judged;
   logic                  in_region;
   logic [19:0]           lhs;
   logic signed [7:0]     factor;
   logic signed [21:0]    rhs;

   assign in_region = (blk.column >= GRID_BITS'(region.start_col)) &&
                      (blk.column <= GRID_BITS'(region.end_col)) &&
                      (blk.row >= GRID_BITS'(region.start_row)) &&
                      (blk.row <= GRID_BITS'(region.end_row));

   always_comb begin
      total_upd = total_ff;
      clear_upd = clear_ff;
      if (in_region) begin
         if (total_ff != COUNT_MAX) begin
            total_upd = total_ff + 1'b1;
         end
         if (blk.clear && (clear_ff != COUNT_MAX)) begin
            clear_upd = clear_ff + 1'b1;
         end
      end
   end

   always_comb begin
      total_in = total_ff;
      clear_in = clear_ff;
      if (blk.count_en) begin
         if (blk.capture) begin
            total_in = '0;
            clear_in = '0;
         end else begin
            total_in = total_upd;
            clear_in = clear_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         clear_ff <= '0;
      end else begin
         total_ff <= total_in;
         clear_ff <= clear_in;
      end
   end

   always_ff @(posedge clock) begin
      if (blk.count_en && blk.capture) begin
         snap_total_ff <= total_upd;
         snap_clear_ff <= clear_upd;
      end
   end

   // clear*100 > total*(100-threshold), signed on the right
   assign lhs = 20'(snap_clear_ff) * 20'd100;
   assign factor = $signed(PERCENT_FULL) - $signed({1'b0, region.thresh});
   assign rhs = 22'($signed({1'b0, snap_total_ff})) * 22'(factor);

   always_comb begin
      if (!region.enable) begin
         judged = ST_UNSET;
      end else if (training) begin
         judged = ST_TRAINING;
      end else if ($signed({2'b00, lhs}) > rhs) begin
         judged = ST_MOTION;
      end else begin
         judged = ST_NO_MOTION;
      end
   end

   always_comb begin
      link_in_next = link_ff;
      if (chain.load) begin
         link_in_next = judged;
      end else if (chain.shift) begin
         link_in_next = link_in;
      end
   end

   always_ff @(posedge clock) begin
      link_ff <= link_in_next;
   end

   assign link_out = link_ff;

endmodule
